### rtl/ktfp_pkg.sv
// shared constants, pose type and fixed-point helpers for the forward pose unit
package ktfp_pkg;

  localparam int MAX_LINKS     = 64;
  localparam int LINK_BITS     = $clog2(MAX_LINKS);
  localparam int ROT_FRAC_BITS = 14;
  localparam int ENTRY_BITS    = 16;
  localparam int POS_BITS      = 20;
  localparam int ROW_BITS      = 3 * ENTRY_BITS;
  localparam int POSW_BITS     = 60;
  localparam int POSE_BITS     = 3 * ROW_BITS + POSW_BITS;

  localparam int ROT_ACC_BITS  = 2 * ENTRY_BITS + 2;
  localparam int POS_ACC_BITS  = ENTRY_BITS + POS_BITS + 2;
  localparam int ROT_RND_BITS  = ROT_ACC_BITS - ROT_FRAC_BITS;
  localparam int POS_RND_BITS  = POS_ACC_BITS - ROT_FRAC_BITS;
  localparam int POS_SUM_BITS  = POS_RND_BITS + 1;

  localparam logic [ROT_ACC_BITS-1:0] ROT_HALF = ROT_ACC_BITS'(1) << (ROT_FRAC_BITS - 1);
  localparam logic [POS_ACC_BITS-1:0] POS_HALF = POS_ACC_BITS'(1) << (ROT_FRAC_BITS - 1);

  localparam logic MODE_ROOT = 1'b0;
  localparam logic MODE_LINK = 1'b1;

  typedef logic [2:0][ROW_BITS-1:0] rows_t;

  typedef struct packed {
    rows_t                rows;
    logic [POSW_BITS-1:0] pos;
  } pose_t;

  function automatic logic signed [ENTRY_BITS-1:0] rot_entry(logic [ROW_BITS-1:0] row,
                                                             int idx);
    return row[idx*ENTRY_BITS +: ENTRY_BITS];
  endfunction

  function automatic logic signed [POS_BITS-1:0] pos_comp(logic [POSW_BITS-1:0] p, int idx);
    return p[idx*POS_BITS +: POS_BITS];
  endfunction

  function automatic logic signed [2*ENTRY_BITS-1:0] mul_rr(logic signed [ENTRY_BITS-1:0] a,
                                                           logic signed [ENTRY_BITS-1:0] b);
    logic signed [2*ENTRY_BITS-1:0] ax;
    logic signed [2*ENTRY_BITS-1:0] bx;
    ax = a;
    bx = b;
    return ax * bx;
  endfunction

  function automatic logic signed [ENTRY_BITS+POS_BITS-1:0] mul_rp(
      logic signed [ENTRY_BITS-1:0] a, logic signed [POS_BITS-1:0] b);
    logic signed [ENTRY_BITS+POS_BITS-1:0] ax;
    logic signed [ENTRY_BITS+POS_BITS-1:0] bx;
    ax = a;
    bx = b;
    return ax * bx;
  endfunction

  // round half up, then floor shift
  function automatic logic [ROT_RND_BITS-1:0] rnd_rot(logic [ROT_ACC_BITS-1:0] acc);
    logic [ROT_ACC_BITS-1:0] s;
    s = acc + ROT_HALF;
    return s[ROT_ACC_BITS-1:ROT_FRAC_BITS];
  endfunction

  function automatic logic [POS_RND_BITS-1:0] rnd_pos(logic [POS_ACC_BITS-1:0] acc);
    logic [POS_ACC_BITS-1:0] s;
    s = acc + POS_HALF;
    return s[POS_ACC_BITS-1:ROT_FRAC_BITS];
  endfunction

  function automatic logic [ENTRY_BITS-1:0] sat_entry(logic [ROT_RND_BITS-1:0] v);
    logic [ROT_RND_BITS-ENTRY_BITS:0] hi_bits;
    hi_bits = v[ROT_RND_BITS-1:ENTRY_BITS-1];
    if (hi_bits == '0 || hi_bits == '1) begin
      return v[ENTRY_BITS-1:0];
    end else if (v[ROT_RND_BITS-1]) begin
      return {1'b1, {(ENTRY_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(ENTRY_BITS-1){1'b1}}};
    end
  endfunction

  function automatic logic [POS_BITS-1:0] sat_pos(logic [POS_SUM_BITS-1:0] v);
    logic [POS_SUM_BITS-POS_BITS:0] hi_bits;
    hi_bits = v[POS_SUM_BITS-1:POS_BITS-1];
    if (hi_bits == '0 || hi_bits == '1) begin
      return v[POS_BITS-1:0];
    end else if (v[POS_SUM_BITS-1]) begin
      return {1'b1, {(POS_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_BITS-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/kinematic_tree_forward_pose_unit.sv
// forward pose unit: pose store, parent forwarding, pose arithmetic and result register
// the parent read is registered into stage 1 and the pose arithmetic into the result register
// throughput: one item per cycle while out_ready does not stall; the parent pose is read
// from the pose ram on input transfer, or from the result register if the parent is the item just ahead
// reset clears the written mask and all valid flags; the pose ram needs no clearing pass
module kinematic_tree_forward_pose_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [ktfp_pkg::LINK_BITS-1:0]    in_link_index,
  input  logic [ktfp_pkg::LINK_BITS-1:0]    in_parent_index,
  input  logic [ktfp_pkg::ROW_BITS-1:0]     in_rot_row0,
  input  logic [ktfp_pkg::ROW_BITS-1:0]     in_rot_row1,
  input  logic [ktfp_pkg::ROW_BITS-1:0]     in_rot_row2,
  input  logic [ktfp_pkg::POSW_BITS-1:0]    in_offset_xyz,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ktfp_pkg::LINK_BITS-1:0]    out_link,
  output logic [ktfp_pkg::ROW_BITS-1:0]     out_world_row0,
  output logic [ktfp_pkg::ROW_BITS-1:0]     out_world_row1,
  output logic [ktfp_pkg::ROW_BITS-1:0]     out_world_row2,
  output logic [ktfp_pkg::POSW_BITS-1:0]    out_world_position,
  output logic                              out_fault
);
  import ktfp_pkg::*;

  // stage 1
  logic                 s1_valid_r;
  logic                 s1_fwd_r;
  logic                 s1_mode_r;
  logic [LINK_BITS-1:0] s1_link_r;
  logic [LINK_BITS-1:0] s1_parent_r;
  rows_t                s1_rows_r;
  logic [POSW_BITS-1:0] s1_off_r;

  // result register
  logic                 out_valid_r;
  logic [LINK_BITS-1:0] out_link_r;
  rows_t                out_rows_r;
  logic [POSW_BITS-1:0] out_pos_r;
  logic                 out_fault_r;

  logic [MAX_LINKS-1:0] mask_r;
  logic [MAX_LINKS-1:0] mask_nxt;

  logic  s1_adv;
  logic  in_xfer;
  logic  s1_fault;
  logic  s1_wr;
  logic  fwd_hit;
  pose_t ram_pose;
  pose_t parent_pose;
  pose_t calc_pose;
  pose_t s1_pose;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  assign s1_fault = (s1_mode_r == MODE_LINK) &&
                    ((s1_link_r == '0) || !mask_r[s1_parent_r]);
  assign s1_wr    = s1_adv && !s1_fault;
  assign fwd_hit  = s1_wr && (s1_link_r == in_parent_index);

  ktfp_ram #(
    .WIDTH (POSE_BITS),
    .DEPTH (MAX_LINKS)
  ) u_pose_ram (
    .clk     (clk),
    .wr_en   (s1_wr),
    .wr_addr (s1_link_r),
    .wr_data (s1_pose),
    .rd_en   (in_xfer),
    .rd_addr (in_parent_index),
    .rd_data (ram_pose)
  );

  // parent written by the item just ahead sits in the result register
  always_comb begin
    if (s1_fwd_r) begin
      parent_pose.rows = out_rows_r;
      parent_pose.pos  = out_pos_r;
    end else begin
      parent_pose = ram_pose;
    end
  end

  ktfp_pose_calc u_calc (
    .parent_pose (parent_pose),
    .local_rows  (s1_rows_r),
    .offset_xyz  (s1_off_r),
    .result      (calc_pose)
  );

  always_comb begin
    if (s1_mode_r == MODE_ROOT) begin
      s1_pose.rows = s1_rows_r;
      s1_pose.pos  = s1_off_r;
    end else begin
      s1_pose = calc_pose;
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (s1_wr) begin
      mask_nxt[s1_link_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
    end else begin
      mask_r <= mask_nxt;
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_fwd_r    <= fwd_hit;
      s1_mode_r   <= in_mode;
      s1_link_r   <= in_link_index;
      s1_parent_r <= in_parent_index;
      s1_rows_r   <= {in_rot_row2, in_rot_row1, in_rot_row0};
      s1_off_r    <= in_offset_xyz;
    end
    if (s1_adv) begin
      out_link_r  <= s1_link_r;
      out_fault_r <= s1_fault;
      if (s1_fault) begin
        out_rows_r <= '0;
        out_pos_r  <= '0;
      end else begin
        out_rows_r <= s1_pose.rows;
        out_pos_r  <= s1_pose.pos;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_link           = out_link_r;
  assign out_world_row0     = out_rows_r[0];
  assign out_world_row1     = out_rows_r[1];
  assign out_world_row2     = out_rows_r[2];
  assign out_world_position = out_pos_r;
  assign out_fault          = out_fault_r;

endmodule

### rtl/ktfp_ram.sv
// generic single write port, single registered read port ram
module ktfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/ktfp_pose_calc.sv
// world pose arithmetic: R = Rp*Omega and t = tp + Rp*offset with rounding and saturation
module ktfp_pose_calc (
  input  ktfp_pkg::pose_t                    parent_pose,
  input  ktfp_pkg::rows_t                    local_rows,
  input  logic [ktfp_pkg::POSW_BITS-1:0]     offset_xyz,
  output ktfp_pkg::pose_t                    result
);
  import ktfp_pkg::*;

  logic signed [ENTRY_BITS-1:0]   par_e   [3][3];
  logic signed [ENTRY_BITS-1:0]   loc_e   [3][3];
  logic signed [POS_BITS-1:0]     off_c   [3];
  logic signed [POS_BITS-1:0]     tp_c    [3];
  logic signed [ROT_ACC_BITS-1:0] rot_acc [3][3];
  logic signed [POS_ACC_BITS-1:0] pos_acc [3];
  logic signed [POS_RND_BITS-1:0] pos_rnd [3];
  logic signed [POS_SUM_BITS-1:0] pos_sum [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        par_e[r][k] = rot_entry(parent_pose.rows[r], k);
        loc_e[r][k] = rot_entry(local_rows[r], k);
      end
      off_c[r] = pos_comp(offset_xyz, r);
      tp_c[r]  = pos_comp(parent_pose.pos, r);
    end

    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rot_acc[r][c] = '0;
        for (int k = 0; k < 3; k++) begin
          rot_acc[r][c] = rot_acc[r][c] + ROT_ACC_BITS'(mul_rr(par_e[r][k], loc_e[k][c]));
        end
      end
      pos_acc[r] = '0;
      for (int c = 0; c < 3; c++) begin
        pos_acc[r] = pos_acc[r] + POS_ACC_BITS'(mul_rp(par_e[r][c], off_c[c]));
      end
      pos_rnd[r] = rnd_pos(pos_acc[r]);
      pos_sum[r] = POS_SUM_BITS'(tp_c[r]) + POS_SUM_BITS'(pos_rnd[r]);
    end

    result = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        result.rows[r][c*ENTRY_BITS +: ENTRY_BITS] = sat_entry(rnd_rot(rot_acc[r][c]));
      end
      result.pos[r*POS_BITS +: POS_BITS] = sat_pos(pos_sum[r]);
    end
  end

endmodule
